### src/isqrt_pkg.sv
// Shared constants and types for the integer square root block.
package isqrt_pkg;

   localparam int VALUE_BITS = 31;
   localparam int ROOT_FIELD_BITS = 16;
   localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
   localparam int PAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int STEP_BITS = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ROOT_BITS - 1);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } cmd_type;

endpackage

### src/isqrt_req_if.sv
// Request channel: radicand beats with valid/ready handshake.
interface isqrt_req_if;
   logic                                valid;
   logic                                ready;
   logic [isqrt_pkg::VALUE_BITS-1:0]    radicand;

   modport source (output valid, output radicand, input ready);
   modport sink (input valid, input radicand, output ready);
endinterface

### src/isqrt_rsp_if.sv
// Response channel: root beats with valid/ready handshake.
interface isqrt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [isqrt_pkg::ROOT_FIELD_BITS-1:0]  root;

   modport source (output valid, output root, input ready);
   modport sink (input valid, input root, output ready);
endinterface

### src/integer_square_root.sv
// Integer square root: each request beat carries a 31-bit radicand and yields
// one response beat holding floor(sqrt(radicand)) in 16 bits. An item first
// takes the request beat, then produces the 16 root bits one by one through a
// single shared shift, compare and subtract step. The result sits in an output
// register, so a new request beat is taken while the previous root still
// waits; the last step is held off only while that register is full and not
// being drained.
module integer_square_root (
   input  logic               clock,
   input  logic               reset,
   isqrt_req_if.sink          req_if,
   isqrt_rsp_if.source        rsp_if
);

   isqrt_pkg::cmd_type cmd;

   isqrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   isqrt_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .radicand (req_if.radicand),
      .root     (rsp_if.root)
   );

endmodule

### src/isqrt_dp.sv
// Datapath: digit-by-digit restoring square root, one root bit per step.
module isqrt_dp (
   input  logic                                   clock,
   input  isqrt_pkg::cmd_type                     cmd,
   input  logic [isqrt_pkg::VALUE_BITS-1:0]       radicand,
   output logic [isqrt_pkg::ROOT_FIELD_BITS-1:0]  root
);

   logic [isqrt_pkg::PAD_BITS-1:0]         x_ff, x_in;
   logic [isqrt_pkg::REM_BITS-1:0]         rem_ff, rem_in;
   logic [isqrt_pkg::ROOT_BITS-1:0]        q_ff, q_in;
   logic [isqrt_pkg::ROOT_FIELD_BITS-1:0]  root_ff, root_in;

   logic [isqrt_pkg::REM_BITS-1:0]         rem_shift;
   logic [isqrt_pkg::REM_BITS-1:0]         trial;
   logic                                   fits;

   // bring down the next two radicand bits; trial subtrahend is 4q+1
   assign rem_shift = {rem_ff[isqrt_pkg::REM_BITS-3:0], x_ff[isqrt_pkg::PAD_BITS-1 -: 2]};
   assign trial     = {q_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      root_in = root_ff;
      if (cmd.load) begin
         x_in   = isqrt_pkg::PAD_BITS'(radicand);
         rem_in = '0;
         q_in   = '0;
      end else if (cmd.step) begin
         x_in   = x_ff << 2;
         rem_in = fits ? (rem_shift - trial) : rem_shift;
         q_in   = {q_ff[isqrt_pkg::ROOT_BITS-2:0], fits};
      end
      if (cmd.publish) begin
         root_in = isqrt_pkg::ROOT_FIELD_BITS'(q_in);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

### src/isqrt_ctrl.sv
// Controller: sequences the root steps and owns the handshakes.
module isqrt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output isqrt_pkg::cmd_type  cmd
);

   isqrt_pkg::state_type            state_ff, state_in;
   logic [isqrt_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                            valid_ff, valid_in;
   logic                            slot_free;
   logic                            last;

   assign slot_free = !valid_ff || rsp_ready;
   assign last      = (step_ff == isqrt_pkg::LAST_STEP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isqrt_pkg::ST_IDLE: begin
            if (req_valid) state_in = isqrt_pkg::ST_RUN;
         end
         isqrt_pkg::ST_RUN: begin
            if (last && slot_free) state_in = isqrt_pkg::ST_IDLE;
         end
         default: state_in = isqrt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         isqrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         isqrt_pkg::ST_RUN: begin
            // final step waits until the output register can take the root
            cmd.step    = !last || slot_free;
            cmd.publish = last && slot_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.load) step_in = '0;
      else if (cmd.step && !last) step_in = step_ff + 1'b1;

      valid_in = valid_ff;
      if (cmd.publish) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isqrt_pkg::ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
